// ===== rtl/ssfs_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfs_pkg
// Types, codes and the control store of the sprite sheet frame sequencer.
// ----------------------------------------------------------------------------
package ssfs_pkg;

	localparam int CMD_W      = 2;
	localparam int DT_W       = 20;
	localparam int FRAME_W    = 8;
	localparam int END_W      = 9;
	localparam int LEFT_W     = 14;
	localparam int TOP_W      = 20;
	localparam int PERIOD_W   = 24;
	localparam int DIM_W      = 13;
	localparam int TEX_W      = 15;
	localparam int ACC_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int DIVIDEND_W = 32;
	localparam int DIVISOR_W  = 24;
	localparam int DIV_CNT_W  = 5;
	localparam int PC_W       = 5;
	localparam int UCODE_DEPTH = 32;

	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PLAY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PAUSE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH = 3'd4;

	typedef logic [PC_W-1:0] pc_t;
	typedef logic [4:0] op_t;
	typedef logic [3:0] cond_t;

	localparam op_t OP_NOP      = 5'd0;
	localparam op_t OP_ACCEPT   = 5'd1;
	localparam op_t OP_PAUSE    = 5'd2;
	localparam op_t OP_PLAY     = 5'd3;
	localparam op_t OP_ACC_ADD  = 5'd4;
	localparam op_t OP_ADV_SUB  = 5'd5;
	localparam op_t OP_ADV_DECN = 5'd6;
	localparam op_t OP_DIV_COLS = 5'd7;
	localparam op_t OP_WAIT_DIV = 5'd8;
	localparam op_t OP_DIV_IDX  = 5'd9;
	localparam op_t OP_MUL      = 5'd10;
	localparam op_t OP_PLACE    = 5'd11;
	localparam op_t OP_DIV_N    = 5'd12;
	localparam op_t OP_TAKE_N   = 5'd13;
	localparam op_t OP_DIV_LEN  = 5'd14;
	localparam op_t OP_TAKE_REM = 5'd15;
	localparam op_t OP_EMIT     = 5'd16;

	localparam cond_t COND_NEVER       = 4'd0;
	localparam cond_t COND_ALWAYS      = 4'd1;
	localparam cond_t COND_CMD_TICK    = 4'd2;
	localparam cond_t COND_CMD_PLAY    = 4'd3;
	localparam cond_t COND_CMD_PAUSE   = 4'd4;
	localparam cond_t COND_NOT_PLAYING = 4'd5;
	localparam cond_t COND_PERIOD_ZERO = 4'd6;
	localparam cond_t COND_LOOP        = 4'd7;
	localparam cond_t COND_NL_DONE     = 4'd8;
	localparam cond_t COND_NO_RELOAD   = 4'd9;
	localparam cond_t COND_N_ZERO      = 4'd10;
	localparam cond_t COND_RET         = 4'd11;

	localparam pc_t A_IDLE    = 5'd0;
	localparam pc_t A_PAUSE   = 5'd5;
	localparam pc_t A_PLAY    = 5'd6;
	localparam pc_t A_TICK    = 5'd8;
	localparam pc_t A_NL_TEST = 5'd11;
	localparam pc_t A_LOOP    = 5'd13;
	localparam pc_t A_N_TEST  = 5'd16;
	localparam pc_t A_M_TEST  = 5'd22;
	localparam pc_t A_PLACE   = 5'd24;
	localparam pc_t A_EMIT    = 5'd30;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  call;
		pc_t   target;
	} uword_t;

	// Control store. A taken condition jumps to the target (a return goes to the
	// saved address), otherwise the step counter moves on by one.
	localparam uword_t UCODE [0:UCODE_DEPTH-1] = '{
		'{OP_ACCEPT,   COND_NEVER,       1'b0, A_IDLE},
		'{OP_NOP,      COND_CMD_TICK,    1'b0, A_TICK},
		'{OP_NOP,      COND_CMD_PLAY,    1'b0, A_PLAY},
		'{OP_NOP,      COND_CMD_PAUSE,   1'b0, A_PAUSE},
		'{OP_NOP,      COND_ALWAYS,      1'b0, A_EMIT},
		'{OP_PAUSE,    COND_ALWAYS,      1'b0, A_EMIT},
		'{OP_PLAY,     COND_ALWAYS,      1'b1, A_PLACE},
		'{OP_NOP,      COND_ALWAYS,      1'b0, A_EMIT},
		'{OP_NOP,      COND_NOT_PLAYING, 1'b0, A_EMIT},
		'{OP_ACC_ADD,  COND_PERIOD_ZERO, 1'b0, A_EMIT},
		'{OP_NOP,      COND_LOOP,        1'b0, A_LOOP},
		'{OP_NOP,      COND_NL_DONE,     1'b0, A_EMIT},
		'{OP_ADV_SUB,  COND_ALWAYS,      1'b0, A_NL_TEST},
		'{OP_DIV_N,    COND_NEVER,       1'b0, A_IDLE},
		'{OP_WAIT_DIV, COND_NEVER,       1'b0, A_IDLE},
		'{OP_TAKE_N,   COND_NEVER,       1'b0, A_IDLE},
		'{OP_NOP,      COND_N_ZERO,      1'b0, A_EMIT},
		'{OP_ADV_DECN, COND_NO_RELOAD,   1'b0, A_N_TEST},
		'{OP_NOP,      COND_ALWAYS,      1'b1, A_PLACE},
		'{OP_DIV_LEN,  COND_NEVER,       1'b0, A_IDLE},
		'{OP_WAIT_DIV, COND_NEVER,       1'b0, A_IDLE},
		'{OP_TAKE_REM, COND_NEVER,       1'b0, A_IDLE},
		'{OP_NOP,      COND_N_ZERO,      1'b0, A_EMIT},
		'{OP_ADV_DECN, COND_ALWAYS,      1'b0, A_M_TEST},
		'{OP_DIV_COLS, COND_NEVER,       1'b0, A_IDLE},
		'{OP_WAIT_DIV, COND_NEVER,       1'b0, A_IDLE},
		'{OP_DIV_IDX,  COND_NEVER,       1'b0, A_IDLE},
		'{OP_WAIT_DIV, COND_NEVER,       1'b0, A_IDLE},
		'{OP_MUL,      COND_NEVER,       1'b0, A_IDLE},
		'{OP_PLACE,    COND_RET,         1'b0, A_IDLE},
		'{OP_EMIT,     COND_ALWAYS,      1'b0, A_IDLE},
		'{OP_NOP,      COND_ALWAYS,      1'b0, A_IDLE}
	};

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  busy;
		logic [DIVIDEND_W-1:0] quot;
		logic [DIVISOR_W-1:0]  rem;
	} div_rsp_t;

endpackage

// ===== rtl/ssfs_if.sv =====
// ----------------------------------------------------------------------------
// ssfs_if
// Handshake channels of the sprite sheet frame sequencer: command items,
// result items and register writes.
// ----------------------------------------------------------------------------
interface ssfs_req_if;
	import ssfs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic [DT_W-1:0]         elapsed_time;
	logic [FRAME_W-1:0]      start_frame;
	logic signed [END_W-1:0] end_frame;
	logic                    loop_enable;
	logic                    pause;

	modport source (output valid, command, elapsed_time, start_frame, end_frame,
		loop_enable, pause, input ready);
	modport sink (input valid, command, elapsed_time, start_frame, end_frame,
		loop_enable, pause, output ready);
endinterface

interface ssfs_rsp_if;
	import ssfs_pkg::*;

	logic               valid;
	logic               ready;
	logic [LEFT_W-1:0]  rect_left;
	logic [TOP_W-1:0]   rect_top;
	logic [FRAME_W-1:0] current_frame;
	logic               is_playing;

	modport source (output valid, rect_left, rect_top, current_frame, is_playing,
		input ready);
	modport sink (input valid, rect_left, rect_top, current_frame, is_playing,
		output ready);
endinterface

interface ssfs_cfg_if;
	import ssfs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ssfs_div.sv =====
// ----------------------------------------------------------------------------
// ssfs_div
// Restoring divider, one quotient bit per cycle, shared by every division
// of the sequencer.
// ----------------------------------------------------------------------------
module ssfs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ssfs_pkg::div_req_t req,
	output ssfs_pkg::div_rsp_t rsp
);
	import ssfs_pkg::*;

	logic                  busy_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVIDEND_W-1:0] q_q;
	logic [DIVISOR_W-1:0]  r_q;
	logic [DIVISOR_W-1:0]  d_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W+1:0]  diff;
	logic                  ge;

	assign shifted = {r_q, q_q[DIVIDEND_W-1]};
	assign diff    = {1'b0, shifted} - {2'b0, d_q};
	assign ge      = !diff[DIVISOR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.dividend;
			r_q <= '0;
			d_q <= req.divisor;
		end else if (busy_q) begin
			q_q <= {q_q[DIVIDEND_W-2:0], ge};
			r_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quot = q_q;
	assign rsp.rem  = r_q;

endmodule

// ===== rtl/sprite_sheet_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// sprite_sheet_frame_sequencer
// Microcoded frame sequencer for a sprite sheet: play, tick and pause items.
// One item at a time; the next item is taken once the result is registered.
// Pause and unknown items go straight to the result; a play places its start
// frame with two divider passes. A tick emits at once while stopped and steps
// one frame at a time when not looping; when looping it adds up to four divider
// passes. Asynchronous reset returns the control state, the sheet and animation
// registers and the result valid flag to their reset values; no item is in flight after reset.
// ----------------------------------------------------------------------------
module sprite_sheet_frame_sequencer (
	input  logic     clk,
	input  logic     arst_n,
	ssfs_cfg_if.sink cfg,
	ssfs_req_if.sink req,
	ssfs_rsp_if.source rsp
);
	import ssfs_pkg::*;

	pc_t    pc_q;
	pc_t    ret_q;
	uword_t uw;
	logic   take;
	logic   stall;
	logic   req_acc;
	logic   out_free;
	logic   emit_go;

	logic [CMD_W-1:0]   cmd_q;
	logic [DT_W-1:0]    dt_q;
	logic [FRAME_W-1:0] start_q;
	logic [END_W-1:0]   end_q;
	logic               loop_in_q;
	logic               pause_q;

	logic [PERIOD_W-1:0] period_q;
	logic [FRAME_W-1:0]  count_q;
	logic [DIM_W-1:0]    fw_q;
	logic [DIM_W-1:0]    fh_q;
	logic [TEX_W-1:0]    tw_q;

	logic               playing_q;
	logic               loop_q;
	logic [FRAME_W-1:0] fi_q;
	logic [FRAME_W-1:0] rf_q;
	logic [FRAME_W-1:0] rl_q;
	logic [ACC_W-1:0]   acc_q;
	logic [LEFT_W-1:0]  left_q;
	logic [TOP_W-1:0]   top_q;

	logic [FRAME_W-1:0]    place_idx_q;
	logic [DIVIDEND_W-1:0] n_q;
	logic [20:0]           prod_left_q;
	logic [20:0]           prod_top_q;

	logic               out_valid_q;
	logic [LEFT_W-1:0]  out_left_q;
	logic [TOP_W-1:0]   out_top_q;
	logic [FRAME_W-1:0] out_frame_q;
	logic               out_playing_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [DIM_W-1:0]   efw;
	logic [TEX_W-1:0]   cols;
	logic [FRAME_W:0]   len;
	logic [15:0]        left_sum;
	logic               wrap;
	logic [TOP_W:0]     top_sum;
	logic [LEFT_W-1:0]  adv_left;
	logic [TOP_W-1:0]   adv_top;
	logic [FRAME_W-1:0] adv_fi;
	logic               adv_playing;
	logic [FRAME_W:0]   fi_next;
	logic               over;
	logic               reload;
	logic [ACC_W:0]     acc_sum;
	logic               nl_done;

	assign uw       = UCODE[pc_q];
	assign req_acc  = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign emit_go  = (uw.op == OP_EMIT) && out_free;

	assign req.ready = (pc_q == A_IDLE);
	assign cfg.ready = 1'b1;

	assign efw     = (fw_q == '0) ? DIM_W'(1) : fw_q;
	assign cols    = (div_rsp.quot == '0) ? TEX_W'(1) : div_rsp.quot[TEX_W-1:0];
	assign len     = (rf_q <= rl_q) ? ({1'b0, rl_q} - {1'b0, rf_q} + 9'd1) : 9'd1;
	assign fi_next = {1'b0, fi_q} + 9'd1;
	assign over    = fi_next > {1'b0, rl_q};
	assign reload  = over && loop_q;
	assign acc_sum = {1'b0, acc_q} + {13'b0, dt_q};
	assign nl_done = (acc_q < {8'b0, period_q}) || (fi_q >= rl_q);

	// One frame step: move right, wrap to the next row at the texture edge.
	always_comb begin
		left_sum    = {2'b0, left_q} + {3'b0, fw_q};
		wrap        = ({1'b0, left_sum} + {4'b0, fw_q}) > {2'b0, tw_q};
		top_sum     = {1'b0, top_q} + {8'b0, fh_q};
		adv_left    = '0;
		adv_top     = top_q;
		adv_fi      = fi_next[FRAME_W-1:0];
		adv_playing = playing_q;
		if (wrap) begin
			adv_top = top_sum[TOP_W] ? '1 : top_sum[TOP_W-1:0];
		end else begin
			adv_left = (left_sum[15:LEFT_W] != '0) ? '1 : left_sum[LEFT_W-1:0];
		end
		if (over) begin
			if (loop_q) begin
				adv_fi = fi_q;
			end else begin
				adv_playing = 1'b0;
			end
		end
	end

	always_comb begin
		unique case (uw.cond)
			COND_NEVER:       take = 1'b0;
			COND_ALWAYS:      take = 1'b1;
			COND_CMD_TICK:    take = (cmd_q == CMD_TICK);
			COND_CMD_PLAY:    take = (cmd_q == CMD_PLAY);
			COND_CMD_PAUSE:   take = (cmd_q == CMD_PAUSE);
			COND_NOT_PLAYING: take = !playing_q;
			COND_PERIOD_ZERO: take = (period_q == '0);
			COND_LOOP:        take = loop_q;
			COND_NL_DONE:     take = nl_done;
			COND_NO_RELOAD:   take = !reload;
			COND_N_ZERO:      take = (n_q == '0);
			COND_RET:         take = 1'b1;
			default:          take = 1'b0;
		endcase
	end

	always_comb begin
		unique case (uw.op)
			OP_ACCEPT:   stall = !req_acc;
			OP_WAIT_DIV: stall = div_rsp.busy;
			OP_EMIT:     stall = !out_free;
			default:     stall = 1'b0;
		endcase
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = acc_q;
		div_req.divisor  = period_q;
		unique case (uw.op)
			OP_DIV_COLS: begin
				div_req.start    = 1'b1;
				div_req.dividend = {17'b0, tw_q};
				div_req.divisor  = {11'b0, efw};
			end
			OP_DIV_IDX: begin
				div_req.start    = 1'b1;
				div_req.dividend = {24'b0, place_idx_q};
				div_req.divisor  = {9'b0, cols};
			end
			OP_DIV_N: begin
				div_req.start = 1'b1;
			end
			OP_DIV_LEN: begin
				div_req.start    = 1'b1;
				div_req.dividend = n_q;
				div_req.divisor  = {15'b0, len};
			end
			default: begin
			end
		endcase
	end

	ssfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= A_IDLE;
			ret_q <= A_IDLE;
		end else if (!stall) begin
			if (take) begin
				pc_q <= (uw.cond == COND_RET) ? ret_q : uw.target;
				if (uw.call) begin
					ret_q <= pc_q + 1'b1;
				end
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			count_q  <= '0;
			fw_q     <= DIM_W'(1);
			fh_q     <= DIM_W'(1);
			tw_q     <= TEX_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FRAME_PERIOD:  period_q <= cfg.data[PERIOD_W-1:0];
				REG_FRAME_COUNT:   count_q  <= cfg.data[FRAME_W-1:0];
				REG_FRAME_WIDTH:   fw_q     <= cfg.data[DIM_W-1:0];
				REG_FRAME_HEIGHT:  fh_q     <= cfg.data[DIM_W-1:0];
				REG_TEXTURE_WIDTH: tw_q     <= cfg.data[TEX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			loop_q    <= 1'b0;
			fi_q      <= '0;
			rf_q      <= '0;
			rl_q      <= '0;
			acc_q     <= '0;
			left_q    <= '0;
			top_q     <= '0;
		end else begin
			unique case (uw.op)
				OP_PAUSE: playing_q <= !pause_q;
				OP_PLAY: begin
					loop_q    <= loop_in_q;
					playing_q <= end_q[FRAME_W] || ({1'b0, start_q} != end_q);
					rf_q      <= start_q;
					rl_q      <= end_q[FRAME_W] ? (count_q - 8'd1) : end_q[FRAME_W-1:0];
				end
				OP_ACC_ADD: acc_q <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
				OP_ADV_SUB: begin
					left_q    <= adv_left;
					top_q     <= adv_top;
					fi_q      <= adv_fi;
					playing_q <= adv_playing;
					acc_q     <= acc_q - {8'b0, period_q};
				end
				OP_ADV_DECN: begin
					left_q    <= adv_left;
					top_q     <= adv_top;
					fi_q      <= adv_fi;
					playing_q <= adv_playing;
				end
				OP_PLACE: begin
					left_q <= (prod_left_q[20:LEFT_W] != '0) ? '1 : prod_left_q[LEFT_W-1:0];
					top_q  <= prod_top_q[TOP_W] ? '1 : prod_top_q[TOP_W-1:0];
					fi_q   <= place_idx_q;
				end
				OP_TAKE_N: acc_q <= {8'b0, div_rsp.rem};
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q     <= req.command;
			dt_q      <= req.elapsed_time;
			start_q   <= req.start_frame;
			end_q     <= $unsigned(req.end_frame);
			loop_in_q <= req.loop_enable;
			pause_q   <= req.pause;
		end
		unique case (uw.op)
			OP_PLAY:     place_idx_q <= start_q;
			OP_ADV_SUB:  place_idx_q <= rf_q;
			OP_ADV_DECN: begin
				place_idx_q <= rf_q;
				n_q         <= n_q - 1'b1;
			end
			OP_MUL: begin
				prod_left_q <= {13'b0, div_rsp.rem[FRAME_W-1:0]} * {8'b0, efw};
				prod_top_q  <= {13'b0, div_rsp.quot[FRAME_W-1:0]} * {8'b0, fh_q};
			end
			OP_TAKE_N:   n_q <= div_rsp.quot;
			OP_TAKE_REM: n_q <= {8'b0, div_rsp.rem};
			default: begin
			end
		endcase
		if (emit_go) begin
			out_left_q    <= left_q;
			out_top_q     <= top_q;
			out_frame_q   <= fi_q;
			out_playing_q <= playing_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.rect_left     = out_left_q;
	assign rsp.rect_top      = out_top_q;
	assign rsp.current_frame = out_frame_q;
	assign rsp.is_playing    = out_playing_q;

endmodule

// ===== rtl/ssfs_chk.sv =====
// ----------------------------------------------------------------------------
// ssfs_chk
// Port-level checks of the sprite sheet frame sequencer, bound to the top.
// ----------------------------------------------------------------------------
module ssfs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [13:0] rect_left,
	input logic [19:0] rect_top,
	input logic [7:0]  current_frame,
	input logic        is_playing
);
	import ssfs_pkg::*;

	logic [2:0] pending_q;

	// Items taken in but whose result has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {2'b0, req_valid && req_ready}
				- {2'b0, rsp_valid && rsp_ready};
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result item withdrawn before it was taken");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rect_left) && $stable(rect_top)
			&& $stable(current_frame) && $stable(is_playing))
		else $error("stalled result item changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 3'd0)
		else $error("result item offered with no item outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more items outstanding than the sequencer can hold");

endmodule

bind sprite_sheet_frame_sequencer ssfs_chk u_ssfs_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rect_left     (rsp.rect_left),
	.rect_top      (rsp.rect_top),
	.current_frame (rsp.current_frame),
	.is_playing    (rsp.is_playing)
);

// ===== bench/sprite_sheet_frame_sequencer_check.sv =====
// ----------------------------------------------------------------------------
// sprite_sheet_frame_sequencer_check
// Watches the register, command and result channels of the frame sequencer.
// It keeps its own copy of the sheet registers and the animation state, works
// out the view each accepted command item should produce, and compares every
// accepted result item with the oldest view still waiting.
// ----------------------------------------------------------------------------
module sprite_sheet_frame_sequencer_check (
	input  logic clk,
	input  logic arst_n,
	ssfs_cfg_if  cfg,
	ssfs_req_if  req,
	ssfs_rsp_if  rsp,
	output int   failures,
	output int   pending
);
	import ssfs_pkg::*;

	localparam logic [63:0] LEFT_LIMIT = 64'd16383;
	localparam logic [63:0] TOP_LIMIT  = 64'd1048575;
	localparam logic [63:0] ACC_LIMIT  = 64'hFFFF_FFFF;
	localparam int          PRINT_CAP  = 40;

	typedef struct packed {
		logic [LEFT_W-1:0]  left;
		logic [TOP_W-1:0]   top;
		logic [FRAME_W-1:0] frame;
		logic               playing;
	} sprite_view_t;

	sprite_view_t expected_views[$];

	logic [PERIOD_W-1:0] period;
	logic [FRAME_W-1:0]  sheet_frames;
	logic [DIM_W-1:0]    frame_w;
	logic [DIM_W-1:0]    frame_h;
	logic [TEX_W-1:0]    tex_w;

	logic               playing;
	logic               looping;
	logic [FRAME_W-1:0] frame_idx;
	logic [FRAME_W-1:0] first;
	logic [FRAME_W-1:0] last;
	logic [ACC_W-1:0]   acc;
	logic [LEFT_W-1:0]  left;
	logic [TOP_W-1:0]   top;

	int error_count = 0;
	int results_seen = 0;

	task automatic report_error(input string what);
		if (error_count < PRINT_CAP)
			$display("error at result %0d: %s", results_seen, what);
		error_count++;
	endtask

	function automatic logic [63:0] clamp(input logic [63:0] v, input logic [63:0] lim);
		return (v > lim) ? lim : v;
	endfunction

	function automatic void place_frame(input logic [FRAME_W-1:0] idx);
		logic [63:0] w;
		logic [63:0] cols;
		w = (frame_w == 0) ? 64'd1 : 64'(frame_w);
		cols = 64'(tex_w) / w;
		if (cols == 0)
			cols = 64'd1;
		left = LEFT_W'(clamp((64'(idx) % cols) * w, LEFT_LIMIT));
		top = TOP_W'(clamp((64'(idx) / cols) * 64'(frame_h), TOP_LIMIT));
		frame_idx = idx;
	endfunction

	// Moves one frame on; tells whether the range start was reloaded.
	function automatic bit step_frame();
		logic [63:0] nx_left;
		logic [8:0]  nx_frame;
		nx_left = 64'(left) + 64'(frame_w);
		if (nx_left + 64'(frame_w) > 64'(tex_w)) begin
			nx_left = 64'd0;
			top = TOP_W'(clamp(64'(top) + 64'(frame_h), TOP_LIMIT));
		end
		left = LEFT_W'(clamp(nx_left, LEFT_LIMIT));
		nx_frame = {1'b0, frame_idx} + 9'd1;
		if (nx_frame > {1'b0, last}) begin
			if (looping) begin
				place_frame(first);
				return 1'b1;
			end
			playing = 1'b0;
		end
		frame_idx = nx_frame[FRAME_W-1:0];
		return 1'b0;
	endfunction

	function automatic void apply_tick(input logic [DT_W-1:0] dt);
		logic [63:0] sum;
		logic [63:0] steps;
		logic [63:0] room;
		logic [63:0] span;
		if (!playing)
			return;
		sum = 64'(acc) + 64'(dt);
		acc = ACC_W'(clamp(sum, ACC_LIMIT));
		if (period == 0)
			return;
		steps = 64'(acc) / 64'(period);
		if (!looping) begin
			room = (frame_idx < last) ? 64'(last - frame_idx) : 64'd0;
			if (steps > room)
				steps = room;
			acc = acc - ACC_W'(steps * 64'(period));
			while (steps > 0) begin
				void'(step_frame());
				steps--;
			end
			return;
		end
		acc = acc - ACC_W'(steps * 64'(period));
		while (steps > 0) begin
			steps--;
			if (step_frame())
				break;
		end
		// Whole laps of the range change nothing, so only the remainder is stepped.
		if (steps > 0) begin
			span = (first <= last) ? 64'(last - first) + 64'd1 : 64'd1;
			steps = steps % span;
			while (steps > 0) begin
				void'(step_frame());
				steps--;
			end
		end
	endfunction

	function automatic void apply_play(input logic [FRAME_W-1:0] start,
			input logic [END_W-1:0] stop_at, input logic loop_en);
		looping = loop_en;
		playing = stop_at[END_W-1] || ({1'b0, start} != stop_at);
		first = start;
		last = stop_at[END_W-1] ? sheet_frames - 8'd1 : stop_at[FRAME_W-1:0];
		place_frame(start);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		sprite_view_t want;
		if (!arst_n) begin
			period = '0;
			sheet_frames = '0;
			frame_w = DIM_W'(1);
			frame_h = DIM_W'(1);
			tex_w = TEX_W'(1);
			playing = 1'b0;
			looping = 1'b0;
			frame_idx = '0;
			first = '0;
			last = '0;
			acc = '0;
			left = '0;
			top = '0;
			expected_views.delete();
			pending <= 0;
			failures <= error_count;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_FRAME_PERIOD:  period = cfg.data[PERIOD_W-1:0];
					REG_FRAME_COUNT:   sheet_frames = cfg.data[FRAME_W-1:0];
					REG_FRAME_WIDTH:   frame_w = cfg.data[DIM_W-1:0];
					REG_FRAME_HEIGHT:  frame_h = cfg.data[DIM_W-1:0];
					REG_TEXTURE_WIDTH: tex_w = cfg.data[TEX_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				case (req.command)
					CMD_TICK:  apply_tick(req.elapsed_time);
					CMD_PLAY:  apply_play(req.start_frame, req.end_frame, req.loop_enable);
					CMD_PAUSE: playing = !req.pause;
					default: ;
				endcase
				expected_views.push_back('{left, top, frame_idx, playing});
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_views.size() == 0) begin
					report_error("result item arrived with nothing expected");
				end else begin
					want = expected_views.pop_front();
					if (rsp.rect_left !== want.left)
						report_error($sformatf("rect_left %0d, expected %0d",
							rsp.rect_left, want.left));
					if (rsp.rect_top !== want.top)
						report_error($sformatf("rect_top %0d, expected %0d",
							rsp.rect_top, want.top));
					if (rsp.current_frame !== want.frame)
						report_error($sformatf("current_frame %0d, expected %0d",
							rsp.current_frame, want.frame));
					if (rsp.is_playing !== want.playing)
						report_error($sformatf("is_playing %0b, expected %0b",
							rsp.is_playing, want.playing));
				end
				results_seen++;
			end
			pending <= expected_views.size();
			failures <= error_count;
		end
	end
endmodule

// ===== bench/sprite_sheet_frame_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// sprite_sheet_frame_sequencer_tb
// Drives the frame sequencer with register writes and command items: a
// directed run over the special cases, then random items under a series of
// sheet settings and idling patterns, one of them with a long hold-off on
// results.
// ----------------------------------------------------------------------------
module sprite_sheet_frame_sequencer_tb;
	import ssfs_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [END_W-1:0] END_AT_LAST = 9'h1FF;
	localparam logic [END_W-1:0] END_MOST_NEG = 9'h100;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_ITEMS = 560;
	localparam int ITEMS_PER_SETTING = 35;

	typedef struct {
		logic [CMD_W-1:0]   command;
		logic [DT_W-1:0]    elapsed;
		logic [FRAME_W-1:0] start;
		logic [END_W-1:0]   stop_at;
		logic               loop_en;
		logic               pause;
	} sprite_cmd_t;

	logic clk = 1'b0;
	logic arst_n;
	int sender_idle_pct = 0;
	int stall_pct = 0;
	logic long_hold = 1'b0;
	int hold_count = 0;
	int quiet = 0;
	int failures;
	int pending;
	logic [PERIOD_W-1:0] cur_period = '0;
	logic [FRAME_W-1:0] cur_frames = '0;

	ssfs_cfg_if cfg();
	ssfs_req_if req();
	ssfs_rsp_if rsp();

	sprite_sheet_frame_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.rsp(rsp)
	);

	sprite_sheet_frame_sequencer_check frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.rsp(rsp),
		.failures(failures),
		.pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (long_hold && hold_count < HOLD_CYCLES) begin
			rsp.ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			rsp.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (quiet == QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic drain();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
	endtask

	task automatic set_sheet(input logic [PERIOD_W-1:0] period, input logic [FRAME_W-1:0] frames,
			input logic [DIM_W-1:0] fw, input logic [DIM_W-1:0] fh, input logic [TEX_W-1:0] tw);
		drain();
		write_reg(REG_FRAME_PERIOD, CFG_DATA_W'(period));
		write_reg(REG_FRAME_COUNT, CFG_DATA_W'(frames));
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(fw));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(fh));
		write_reg(REG_TEXTURE_WIDTH, CFG_DATA_W'(tw));
		cfg.valid <= 1'b0;
		cur_period = period;
		cur_frames = frames;
	endtask

	task automatic send_item(input sprite_cmd_t c);
		while ($urandom_range(99) < sender_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= c.command;
		req.elapsed_time <= c.elapsed;
		req.start_frame <= c.start;
		req.end_frame <= c.stop_at;
		req.loop_enable <= c.loop_en;
		req.pause <= c.pause;
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	function automatic sprite_cmd_t make_cmd(input logic [CMD_W-1:0] command,
			input logic [DT_W-1:0] elapsed, input logic [FRAME_W-1:0] start,
			input logic [END_W-1:0] stop_at, input logic loop_en, input logic pause);
		sprite_cmd_t c;
		c.command = command;
		c.elapsed = elapsed;
		c.start = start;
		c.stop_at = stop_at;
		c.loop_en = loop_en;
		c.pause = pause;
		return c;
	endfunction

	// Mostly ticks sized against the frame period, with plays mostly bounded by the
	// frame count and pauses that more often resume; the fields a command ignores stay random.
	function automatic sprite_cmd_t random_cmd();
		sprite_cmd_t c;
		int unsigned pick;
		int unsigned span;
		c.elapsed = DT_W'($urandom);
		c.start = FRAME_W'($urandom);
		c.stop_at = END_W'($urandom);
		c.loop_en = 1'($urandom);
		c.pause = 1'($urandom);
		pick = $urandom_range(99);
		if (pick < 58) begin
			c.command = CMD_TICK;
			case ($urandom_range(5))
				0: c.elapsed = '0;
				1: c.elapsed = '1;
				2: ;
				default: begin
					span = (cur_period == 0) ? 32'd5000 : 3 * cur_period;
					pick = $urandom_range(span);
					c.elapsed = (pick > 32'hFFFFF) ? '1 : pick[DT_W-1:0];
				end
			endcase
		end else if (pick < 80) begin
			c.command = CMD_PLAY;
			if ($urandom_range(3) != 0)
				c.start = FRAME_W'($urandom_range(cur_frames));
			case ($urandom_range(3))
				0: c.stop_at = END_AT_LAST;
				1: ;
				default: c.stop_at = END_W'($urandom_range(cur_frames));
			endcase
		end else if (pick < 95) begin
			c.command = CMD_PAUSE;
			c.pause = ($urandom_range(3) == 0);
		end else begin
			c.command = CMD_UNUSED;
		end
		return c;
	endfunction

	initial begin
		logic [PERIOD_W-1:0] r_period;
		logic [FRAME_W-1:0] r_frames;
		logic [DIM_W-1:0] r_fw;
		logic [DIM_W-1:0] r_fh;
		logic [TEX_W-1:0] r_tw;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.command <= CMD_TICK;
		req.elapsed_time <= '0;
		req.start_frame <= '0;
		req.end_frame <= '0;
		req.loop_enable <= 1'b0;
		req.pause <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_FRAME_PERIOD;
		cfg.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: a tick while stopped, an unused code, a resume, then time
		// gathering under a zero period.
		send_item(make_cmd(CMD_TICK, 20'd5, 8'd0, 9'd0, 1'b0, 1'b0));
		send_item(make_cmd(CMD_UNUSED, 20'd0, 8'd0, 9'd0, 1'b0, 1'b0));
		send_item(make_cmd(CMD_PAUSE, 20'd0, 8'd0, 9'd0, 1'b0, 1'b0));
		send_item(make_cmd(CMD_TICK, 20'd100, 8'd0, 9'd0, 1'b0, 1'b0));

		set_sheet(24'd1000, 8'd8, 13'd32, 13'd16, 15'd128);
		send_item(make_cmd(CMD_PLAY, 20'd0, 8'd0, END_AT_LAST, 1'b1, 1'b0));
		send_item(make_cmd(CMD_TICK, 20'd999, 8'd0, 9'd0, 1'b0, 1'b0));
		send_item(make_cmd(CMD_TICK, 20'd1, 8'd0, 9'd0, 1'b0, 1'b0));
		send_item(make_cmd(CMD_TICK, 20'd5500, 8'd0, 9'd0, 1'b0, 1'b0));
		send_item(make_cmd(CMD_TICK, 20'hFFFFF, 8'd0, 9'd0, 1'b0, 1'b0));
		send_item(make_cmd(CMD_PAUSE, 20'd0, 8'd0, 9'd0, 1'b0, 1'b1));
		send_item(make_cmd(CMD_TICK, 20'd5000, 8'd0, 9'd0, 1'b0, 1'b0));
		send_item(make_cmd(CMD_PAUSE, 20'd0, 8'd0, 9'd0, 1'b0, 1'b0));
		send_item(make_cmd(CMD_PLAY, 20'd0, 8'd2, 9'd5, 1'b0, 1'b0));
		send_item(make_cmd(CMD_TICK, 20'd20000, 8'd0, 9'd0, 1'b0, 1'b0));
		send_item(make_cmd(CMD_PLAY, 20'd0, 8'd3, 9'd3, 1'b0, 1'b0));
		send_item(make_cmd(CMD_PLAY, 20'd0, 8'd6, 9'd2, 1'b1, 1'b0));
		send_item(make_cmd(CMD_TICK, 20'd3000, 8'd0, 9'd0, 1'b0, 1'b0));
		send_item(make_cmd(CMD_PLAY, 20'd0, 8'd255, 9'd255, 1'b1, 1'b0));
		send_item(make_cmd(CMD_PLAY, 20'd0, 8'd0, END_MOST_NEG, 1'b0, 1'b0));
		send_item(make_cmd(CMD_UNUSED, 20'hFFFFF, 8'hFF, 9'h1FF, 1'b1, 1'b1));

		// Frames wider than the sheet, no frame count: the last frame wraps to 255.
		set_sheet(24'd1, 8'd0, 13'd4096, 13'd4096, 15'd1);
		send_item(make_cmd(CMD_PLAY, 20'd0, 8'd250, END_AT_LAST, 1'b1, 1'b0));
		send_item(make_cmd(CMD_TICK, 20'hFFFFF, 8'd0, 9'd0, 1'b0, 1'b0));
		send_item(make_cmd(CMD_PLAY, 20'd0, 8'd254, 9'd255, 1'b1, 1'b0));
		send_item(make_cmd(CMD_TICK, 20'd2, 8'd0, 9'd0, 1'b0, 1'b0));

		for (int chunk = 0; chunk < RANDOM_ITEMS / ITEMS_PER_SETTING; chunk++) begin
			if (chunk == 0) begin
				set_sheet(24'hFFFFFF, 8'd255, 13'd4096, 13'd4096, 15'd16384);
			end else if (chunk == 1) begin
				set_sheet(24'd0, 8'd0, 13'd1, 13'd1, 15'd1);
			end else begin
				case ($urandom_range(4))
					0: r_period = '0;
					1: r_period = 24'd1;
					2: r_period = 24'hFFFFFF;
					default: r_period = PERIOD_W'($urandom_range(2, 5000));
				endcase
				case ($urandom_range(3))
					0: r_frames = 8'd0;
					1: r_frames = 8'd255;
					2: r_frames = 8'd1;
					default: r_frames = FRAME_W'($urandom_range(2, 64));
				endcase
				case ($urandom_range(2))
					0: r_fw = 13'd1;
					1: r_fw = 13'd4096;
					default: r_fw = DIM_W'($urandom_range(1, 256));
				endcase
				case ($urandom_range(2))
					0: r_fh = 13'd1;
					1: r_fh = 13'd4096;
					default: r_fh = DIM_W'($urandom_range(1, 512));
				endcase
				case ($urandom_range(2))
					0: r_tw = 15'd1;
					1: r_tw = 15'd16384;
					default: r_tw = TEX_W'($urandom_range(1, 4096));
				endcase
				set_sheet(r_period, r_frames, r_fw, r_fh, r_tw);
			end
			case (chunk % 4)
				0: begin
					sender_idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					sender_idle_pct = 87;
					stall_pct <= 0;
				end
				2: begin
					sender_idle_pct = 0;
					stall_pct <= 87;
				end
				default: begin
					sender_idle_pct = 34;
					stall_pct <= 34;
				end
			endcase
			// Results held back for a long stretch while items are still offered.
			if (chunk == 4)
				long_hold <= 1'b1;
			repeat (ITEMS_PER_SETTING)
				send_item(random_cmd());
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/ssfs_pkg.sv
rtl/ssfs_if.sv
rtl/ssfs_div.sv
rtl/sprite_sheet_frame_sequencer.sv
rtl/ssfs_chk.sv
bench/sprite_sheet_frame_sequencer_check.sv
bench/sprite_sheet_frame_sequencer_tb.sv
